[hdl/ccl_pkg.sv]
// Shared types, codes and the Cyrillic glyph table for the LCD nibble writer.
package ccl_pkg;

    localparam logic [7:0] SYM_CR    = 8'h0D;
    localparam logic [7:0] SYM_LF    = 8'h0A;
    localparam logic [7:0] SYM_BS    = 8'h08;
    localparam logic [7:0] CMD_LINE1 = 8'h80;
    localparam logic [7:0] CMD_LINE2 = 8'hC0;

    localparam logic [7:0] CP_GLYPH_BASE = 8'd192;
    localparam logic [7:0] UTF_LEAD_A    = 8'd208;
    localparam logic [7:0] UTF_LEAD_B    = 8'd209;
    localparam logic [7:0] UTF_HI_FIRST  = 8'd144;
    localparam logic [7:0] UTF_HI_LAST   = 8'd191;
    localparam logic [7:0] UTF_LO_FIRST  = 8'd128;
    localparam logic [7:0] UTF_LO_OFFSET = 8'd80;

    localparam logic RS_INSTR = 1'b0;
    localparam logic RS_DATA  = 1'b1;

    typedef enum logic [2:0] {
        KIND_LINE1,
        KIND_LINE2,
        KIND_BACK,
        KIND_GLYPH,
        KIND_RAW,
        KIND_DROP
    } sym_kind_t;

    typedef struct packed {
        sym_kind_t   kind;
        logic [5:0]  idx;
        logic [7:0]  sym;
    } sym_item_t;

    typedef struct packed {
        logic [7:0]  value;
        logic        rs;
    } lcd_byte_t;

    localparam logic [7:0] GLYPH_ROM [64] = '{
        8'h41, 8'hA0, 8'h42, 8'hA1, 8'hE0, 8'h45, 8'hA3, 8'hA4,
        8'hA5, 8'hA6, 8'h4B, 8'hA7, 8'h4D, 8'h48, 8'h4F, 8'hA8,
        8'h50, 8'h43, 8'h54, 8'hA9, 8'hAA, 8'h58, 8'hE1, 8'hAB,
        8'hAC, 8'hE2, 8'hAD, 8'hAE, 8'h62, 8'hAF, 8'hB0, 8'hB1,
        8'h61, 8'hB2, 8'hB3, 8'hB4, 8'hE3, 8'h65, 8'hB6, 8'hB7,
        8'hB8, 8'hB9, 8'hBA, 8'hBB, 8'hBC, 8'hBD, 8'h6F, 8'hBE,
        8'h70, 8'h63, 8'hBF, 8'h79, 8'hE4, 8'h78, 8'hE5, 8'hC0,
        8'hC1, 8'hE6, 8'hC2, 8'hC3, 8'hC4, 8'hC5, 8'hC6, 8'hC7
    };

endpackage

[hdl/ccl_classify.sv]
// Stage 1: sorts the incoming byte into a kind and a glyph table index.
module ccl_classify (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               utf8_mode,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [7:0]         in_sym,
    output logic               out_valid,
    input  logic               out_ready,
    output ccl_pkg::sym_item_t out_item
);

    logic               valid_reg;
    logic               valid_next;
    ccl_pkg::sym_item_t item_reg;
    ccl_pkg::sym_item_t item_next;
    logic [7:0]         diff_hi;
    logic [7:0]         diff_lo;

    assign diff_hi = in_sym - ccl_pkg::UTF_HI_FIRST;
    assign diff_lo = in_sym - ccl_pkg::UTF_LO_OFFSET;

    always_comb
    begin
        item_next.sym  = in_sym;
        item_next.idx  = in_sym[5:0];
        item_next.kind = ccl_pkg::KIND_RAW;
        if (in_sym == ccl_pkg::SYM_CR)
        begin
            item_next.kind = ccl_pkg::KIND_LINE1;
        end
        else if (in_sym == ccl_pkg::SYM_LF)
        begin
            item_next.kind = ccl_pkg::KIND_LINE2;
        end
        else if (in_sym == ccl_pkg::SYM_BS)
        begin
            item_next.kind = ccl_pkg::KIND_BACK;
        end
        else if (!utf8_mode)
        begin
            if (in_sym >= ccl_pkg::CP_GLYPH_BASE)
            begin
                item_next.kind = ccl_pkg::KIND_GLYPH;
            end
        end
        else if (in_sym == ccl_pkg::UTF_LEAD_A || in_sym == ccl_pkg::UTF_LEAD_B)
        begin
            item_next.kind = ccl_pkg::KIND_DROP;
        end
        else if (in_sym >= ccl_pkg::UTF_HI_FIRST && in_sym <= ccl_pkg::UTF_HI_LAST)
        begin
            item_next.kind = ccl_pkg::KIND_GLYPH;
            item_next.idx  = diff_hi[5:0];
        end
        else if (in_sym >= ccl_pkg::UTF_LO_FIRST && in_sym < ccl_pkg::UTF_HI_FIRST)
        begin
            item_next.kind = ccl_pkg::KIND_GLYPH;
            item_next.idx  = diff_lo[5:0];
        end
        else if (in_sym == 8'd0)
        begin
            item_next.kind = ccl_pkg::KIND_DROP;
        end
    end

    // dropped bytes are swallowed here and never occupy later stages
    assign valid_next = in_valid && (item_next.kind != ccl_pkg::KIND_DROP);
    assign in_ready   = !valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            item_reg <= item_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_item  = item_reg;

endmodule

[hdl/ccl_lookup.sv]
// Stage 2: turns a classified symbol into the LCD byte and register select.
module ccl_lookup (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  ccl_pkg::sym_item_t in_item,
    output logic               out_valid,
    input  logic               out_ready,
    output ccl_pkg::lcd_byte_t out_byte
);

    logic               valid_reg;
    ccl_pkg::lcd_byte_t byte_reg;
    ccl_pkg::lcd_byte_t byte_next;

    always_comb
    begin
        byte_next.rs = ccl_pkg::RS_DATA;
        case (in_item.kind)
            ccl_pkg::KIND_LINE1:
            begin
                byte_next.value = ccl_pkg::CMD_LINE1;
                byte_next.rs    = ccl_pkg::RS_INSTR;
            end
            ccl_pkg::KIND_LINE2:
            begin
                byte_next.value = ccl_pkg::CMD_LINE2;
                byte_next.rs    = ccl_pkg::RS_INSTR;
            end
            ccl_pkg::KIND_BACK:  byte_next.value = 8'h00;
            ccl_pkg::KIND_GLYPH: byte_next.value = ccl_pkg::GLYPH_ROM[in_item.idx];
            default:             byte_next.value = in_item.sym;
        endcase
    end

    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            byte_reg <= byte_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_byte  = byte_reg;

endmodule

[hdl/ccl_serial.sv]
// Stage 3: output register that sends one LCD byte as two nibble requests.
module ccl_serial (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  ccl_pkg::lcd_byte_t in_byte,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [3:0]         out_nibble,
    output logic               out_rs,
    output logic               out_last
);

    logic               valid_reg;
    logic               phase_reg;
    logic               phase_next;
    ccl_pkg::lcd_byte_t byte_reg;

    // a new byte may load as the low nibble leaves
    assign in_ready = !valid_reg || (out_ready && phase_reg);

    always_comb
    begin
        phase_next = phase_reg;
        if (in_ready)
        begin
            phase_next = 1'b0;
        end
        else if (out_ready)
        begin
            phase_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            phase_reg <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            if (in_ready)
            begin
                valid_reg <= in_valid;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            byte_reg <= in_byte;
        end
    end

    assign out_valid  = valid_reg;
    assign out_nibble = phase_reg ? byte_reg.value[3:0] : byte_reg.value[7:4];
    assign out_rs     = byte_reg.rs;
    assign out_last   = phase_reg;

endmodule

[hdl/cyrillic_char_to_lcd_nibbles_top.sv]
// Top level: character byte in, LCD 4-bit bus nibble requests out.
//
// Input channel: char_byte with char_valid / char_ready. A request is taken
// on a rising edge with both high. Output channel: nibble, reg_select and
// last with nib_valid / nib_ready; each accepted character yields either no
// request or two (high nibble first, then low nibble with last set), both
// with the same reg_select. CR and LF become cursor instructions, backspace
// sends data 0, Cyrillic codes go through the glyph table.
// utf8_mode_we / utf8_mode_wdata write the mode bit (0 CP1251, 1 UTF-8);
// write it only while the block is empty.
// The high nibble is offered once the character has moved through the
// classify and lookup registers into the output register, the low nibble
// in the following cycle when the receiver takes each at once.
// A character that produces output leaves as two requests over the single
// nibble port; a new byte loads as its low nibble leaves. Dropped bytes
// (UTF-8 lead bytes, zero in UTF-8 mode) are discarded in the first stage.
// Reset (rst_n low, asynchronous) empties all stages and clears the mode
// bit to CP1251. When nib_ready is low the requests wait in the stages;
// char_ready falls once all three stages are full, and nothing is lost.
module cyrillic_char_to_lcd_nibbles_top (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       utf8_mode_we,
    input  logic       utf8_mode_wdata,
    input  logic       char_valid,
    output logic       char_ready,
    input  logic [7:0] char_byte,
    output logic       nib_valid,
    input  logic       nib_ready,
    output logic [3:0] nibble,
    output logic       reg_select,
    output logic       last
);

    logic               utf8_mode_reg;
    logic               cls_valid;
    logic               cls_ready;
    ccl_pkg::sym_item_t cls_item;
    logic               lut_valid;
    logic               lut_ready;
    ccl_pkg::lcd_byte_t lut_byte;

    // mode register: the user must write it only when the pipeline is empty; the block does not enforce this
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            utf8_mode_reg <= 1'b0;
        end
        else if (utf8_mode_we)
        begin
            utf8_mode_reg <= utf8_mode_wdata;
        end
    end

    ccl_classify u_classify (
        .clk       (clk),
        .rst_n     (rst_n),
        .utf8_mode (utf8_mode_reg),
        .in_valid  (char_valid),
        .in_ready  (char_ready),
        .in_sym    (char_byte),
        .out_valid (cls_valid),
        .out_ready (cls_ready),
        .out_item  (cls_item)
    );

    ccl_lookup u_lookup (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (cls_valid),
        .in_ready  (cls_ready),
        .in_item   (cls_item),
        .out_valid (lut_valid),
        .out_ready (lut_ready),
        .out_byte  (lut_byte)
    );

    ccl_serial u_serial (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (lut_valid),
        .in_ready   (lut_ready),
        .in_byte    (lut_byte),
        .out_valid  (nib_valid),
        .out_ready  (nib_ready),
        .out_nibble (nibble),
        .out_rs     (reg_select),
        .out_last   (last)
    );

endmodule
